[design/ttt_pkg.sv]
`default_nettype none

package ttt_pkg;

   localparam int unsigned BUCKET_BITS_DEFAULT = 10;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 15;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEARCH_AGE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATE_SCORE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INFINITE_SCORE = 2'd2;

   localparam logic [7:0] SEARCH_AGE_RESET = 8'd0;
   localparam logic [14:0] MATE_SCORE_RESET = 15'd32000;
   localparam logic [14:0] INFINITE_SCORE_RESET = 15'd32767;

   localparam int unsigned REQ_TDATA_BITS = 112;
   localparam int unsigned RSP_TDATA_BITS = 48;

   typedef struct packed {
      logic              action;
      logic [63:0]       key;
      logic [15:0]       move;
      logic signed [7:0] draft;
      logic [1:0]        bound;
      logic signed [15:0] value;
   } item_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [15:0]        move;
      logic signed [7:0]  draft;
      logic [1:0]         bound;
      logic signed [15:0] value;
      logic [7:0]         age;
   } slot_type;

   typedef struct packed {
      slot_type second;
      slot_type first;
   } bucket_type;

   typedef struct packed {
      logic               hit;
      logic               from_second;
      logic [15:0]        move;
      logic signed [7:0]  draft;
      logic [1:0]         bound;
      logic signed [15:0] value;
   } result_type;

   typedef struct packed {
      logic [7:0]  search_age;
      logic [14:0] mate_score;
      logic [14:0] infinite_score;
   } cfg_type;

endpackage

`default_nettype wire

[design/ttt_store.sv]
`default_nettype none

module ttt_store #(
   parameter int unsigned BUCKET_BITS = ttt_pkg::BUCKET_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   output logic                         busy,
   input  wire                          rd_en,
   input  wire [BUCKET_BITS-1:0]        rd_addr,
   output ttt_pkg::bucket_type          rd_bucket,
   input  wire                          wr_en,
   input  wire [BUCKET_BITS-1:0]        wr_addr,
   input  ttt_pkg::bucket_type          wr_bucket
);

   localparam int unsigned DEPTH = 1 << BUCKET_BITS;

   ttt_pkg::bucket_type bucket_mem [DEPTH];
   ttt_pkg::bucket_type rd_bucket_ff;

   logic                   clear_ff;
   logic                   clear_in;
   logic [BUCKET_BITS-1:0] clear_addr_ff;
   logic [BUCKET_BITS-1:0] clear_addr_in;

   always_comb begin
      clear_in = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == {BUCKET_BITS{1'b1}}) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         bucket_mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         bucket_mem[wr_addr] <= wr_bucket;
      end
      if (rd_en) begin
         rd_bucket_ff <= bucket_mem[rd_addr];
      end
   end

   assign busy = clear_ff;
   assign rd_bucket = rd_bucket_ff;

endmodule

`default_nettype wire

[design/ttt_update.sv]
`default_nettype none

module ttt_update (
   input  ttt_pkg::item_type    item,
   input  ttt_pkg::bucket_type  old_bucket,
   input  ttt_pkg::cfg_type     cfg,
   output ttt_pkg::bucket_type  new_bucket,
   output logic                 has_result,
   output ttt_pkg::result_type  result
);

   function automatic ttt_pkg::slot_type fill_slot(
      input ttt_pkg::slot_type old_slot,
      input ttt_pkg::item_type it,
      input logic [1:0]        bound,
      input logic [15:0]       value,
      input logic [7:0]        age
   );
      ttt_pkg::slot_type s;
      s.key = it.key;
      s.move = it.move;
      if (it.move == 16'd0 && old_slot.key == it.key) begin
         s.move = old_slot.move;
      end
      s.draft = it.draft;
      s.bound = bound;
      s.value = value;
      s.age = age;
      return s;
   endfunction

   logic               hit_first;
   logic               hit_second;
   logic signed [16:0] value_ext;
   logic signed [16:0] mate_pos;
   logic signed [16:0] mate_neg;
   logic signed [16:0] inf_pos;
   logic signed [16:0] inf_neg;
   logic [1:0]         ins_bound;
   logic [15:0]        ins_value;
   logic               take_second;
   ttt_pkg::slot_type  found;

   always_comb begin
      hit_first = (old_bucket.first.key == item.key);
      hit_second = !hit_first && (old_bucket.second.key == item.key);

      value_ext = {item.value[15], item.value};
      mate_pos = {2'b00, cfg.mate_score};
      mate_neg = -mate_pos;
      inf_pos = {2'b00, cfg.infinite_score};
      inf_neg = -inf_pos;

      ins_bound = item.bound;
      ins_value = item.value;
      if (value_ext >= mate_pos) begin
         if (item.bound == ttt_pkg::BOUND_UPPER) begin
            ins_value = inf_pos[15:0];
         end else begin
            ins_bound = ttt_pkg::BOUND_LOWER;
            ins_value = mate_pos[15:0];
         end
      end else if (value_ext <= mate_neg) begin
         if (item.bound == ttt_pkg::BOUND_LOWER) begin
            ins_value = inf_neg[15:0];
         end else begin
            ins_bound = ttt_pkg::BOUND_UPPER;
            ins_value = mate_neg[15:0];
         end
      end

      take_second = (old_bucket.second.age != cfg.search_age)
         || ($signed(old_bucket.second.draft) <= $signed(item.draft));

      new_bucket = old_bucket;
      if (item.action == ttt_pkg::ACT_INSERT) begin
         new_bucket.first = fill_slot(old_bucket.first, item, ins_bound, ins_value,
            cfg.search_age);
         if (take_second) begin
            new_bucket.second = fill_slot(old_bucket.second, item, ins_bound, ins_value,
               cfg.search_age);
         end
      end else if (hit_second) begin
         new_bucket.second.age = cfg.search_age;
      end

      found = hit_first ? old_bucket.first : old_bucket.second;
      result = '0;
      if (hit_first || hit_second) begin
         result.hit = 1'b1;
         result.from_second = hit_second;
         result.move = found.move;
         result.draft = found.draft;
         result.bound = found.bound;
         result.value = found.value;
      end
      has_result = (item.action == ttt_pkg::ACT_LOOKUP);
   end

endmodule

`default_nettype wire

[design/two_tier_transposition_table.sv]
// Two-tier search-result cache with 2^BUCKET_BITS buckets, each holding an
// always-replace slot and a depth-preferred slot.
// The req channel carries one lookup or insert per item; req_tuser selects the
// action and req_tdata holds the key, move, draft, bound and score.
// Every lookup returns one item on the rsp channel; an insert returns nothing.
// The csr channel writes search_age, mate_score and infinite_score and is
// always ready; it is meant to be used while no item is in flight.
// An accepted item's bucket is read at the accepting edge; in the bucket stage the
// item is resolved and its bucket written back when the stage fires, and a lookup
// result is loaded into the rsp result register at that edge. Back-to-back
// items on the same bucket are forwarded from the last write, so one item per
// cycle is sustained while no lookup waits on rsp. After reset the block sweeps
// the bucket memory to zero, one bucket per cycle; req_tready stays low during
// the sweep. When rsp_tready is low the result register holds its item; a lookup
// behind it waits in the bucket stage and blocks req; an insert there completes.
`default_nettype none

module two_tier_transposition_table #(
   parameter int unsigned BUCKET_BITS = ttt_pkg::BUCKET_BITS_DEFAULT
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_tvalid,
   output logic                                      req_tready,
   // position_key, best_move, search_draft, bound_kind, score_value
   input  wire [ttt_pkg::REQ_TDATA_BITS-1:0]         req_tdata,
   // action
   input  wire                                       req_tuser,
   output logic                                      rsp_tvalid,
   input  wire                                       rsp_tready,
   // found_move, found_draft, found_bound, found_value
   output logic [ttt_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,
   // hit, from_second_slot
   output logic [1:0]                                rsp_tuser,
   input  wire                                       csr_valid,
   output logic                                      csr_ready,
   input  wire [ttt_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  wire [ttt_pkg::CSR_DATA_BITS-1:0]          csr_data
);

   ttt_pkg::cfg_type    cfg_ff;
   ttt_pkg::cfg_type    cfg_in;

   ttt_pkg::item_type   req_item;
   logic                req_accept;
   logic                busy;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   ttt_pkg::item_type   s1_item_ff;
   logic                s1_fire;
   logic [BUCKET_BITS-1:0] s1_idx;

   ttt_pkg::bucket_type rd_bucket;
   ttt_pkg::bucket_type cur_bucket;
   ttt_pkg::bucket_type wr_bucket;
   logic                has_result;
   ttt_pkg::result_type result;

   logic                fwd_valid_ff;
   logic                fwd_valid_in;
   logic [BUCKET_BITS-1:0] fwd_idx_ff;
   ttt_pkg::bucket_type fwd_bucket_ff;

   logic                out_free;
   logic                rsp_load;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   ttt_pkg::result_type rsp_data_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ttt_pkg::CSR_SEARCH_AGE: cfg_in.search_age = csr_data[7:0];
            ttt_pkg::CSR_MATE_SCORE: cfg_in.mate_score = csr_data;
            ttt_pkg::CSR_INFINITE_SCORE: cfg_in.infinite_score = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_age <= ttt_pkg::SEARCH_AGE_RESET;
         cfg_ff.mate_score <= ttt_pkg::MATE_SCORE_RESET;
         cfg_ff.infinite_score <= ttt_pkg::INFINITE_SCORE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_item.action = req_tuser;
      req_item.key = req_tdata[63:0];
      req_item.move = req_tdata[79:64];
      req_item.draft = req_tdata[87:80];
      req_item.bound = req_tdata[89:88];
      req_item.value = req_tdata[105:90];
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_fire = s1_valid_ff
      && ((s1_item_ff.action == ttt_pkg::ACT_INSERT) || out_free);
   assign req_tready = !busy && (!s1_valid_ff || s1_fire);
   assign req_accept = req_tvalid && req_tready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);
   assign s1_idx = s1_item_ff.key[BUCKET_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
   end

   ttt_store #(
      .BUCKET_BITS(BUCKET_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .busy      (busy),
      .rd_en     (req_accept),
      .rd_addr   (req_item.key[BUCKET_BITS-1:0]),
      .rd_bucket (rd_bucket),
      .wr_en     (s1_fire),
      .wr_addr   (s1_idx),
      .wr_bucket (wr_bucket)
   );

   assign cur_bucket = (fwd_valid_ff && (fwd_idx_ff == s1_idx)) ? fwd_bucket_ff : rd_bucket;

   ttt_update u_update (
      .item       (s1_item_ff),
      .old_bucket (cur_bucket),
      .cfg        (cfg_ff),
      .new_bucket (wr_bucket),
      .has_result (has_result),
      .result     (result)
   );

   assign fwd_valid_in = fwd_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         fwd_idx_ff <= s1_idx;
         fwd_bucket_ff <= wr_bucket;
      end
   end

   assign rsp_load = s1_fire && has_result;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'b0, rsp_data_ff.value, rsp_data_ff.bound, rsp_data_ff.draft,
      rsp_data_ff.move};
   assign rsp_tuser = {rsp_data_ff.from_second, rsp_data_ff.hit};

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("Item accepted during the memory clearing sweep.");

   a_stage_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !s1_valid_ff)
      else $error("Bucket stage holds an item during the memory clearing sweep.");

   a_lookup_waits_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && s1_valid_ff
         && s1_item_ff.action == ttt_pkg::ACT_LOOKUP) |-> !s1_fire)
      else $error("Lookup completed while the result register was stalled.");

   a_second_hit_restamps: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_item_ff.action == ttt_pkg::ACT_LOOKUP && result.from_second)
         |-> (wr_bucket.second.age == cfg_ff.search_age))
      else $error("Second slot hit did not restamp the age.");

endmodule

`default_nettype wire
